>>> hw/rtl/smlrq_pkg.sv
`default_nettype none
package smlrq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LEVEL_W = 5;
    localparam int ROW_W   = 15;
    localparam int COL_W   = 16;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               present;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t word;
    } cmd_t;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic   ins;
        entry_t word;
    } link_t;

endpackage
`default_nettype wire

>>> hw/rtl/stable_min_level_request_queue_top.sv
`default_nettype none
// Request queue of DEPTH words kept in a row of cells, sorted on every push:
// tiled requests by ascending level (oldest first on equal level), then
// tile-less requests newest first. A pop always takes the head cell, which
// is the lowest-level tiled request or, when none has a tile, the newest
// one. Each push or pop updates the cell row and its result is registered
// in an output register; a new word is taken whenever that register is
// empty or being read, so one operation per cycle is sustained.
module stable_min_level_request_queue_top
    import smlrq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [ROW_W-1:0]   tile_row,
    input  wire logic [COL_W-1:0]   tile_col,
    input  wire logic               tile_present,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [LEVEL_W-1:0]      out_level,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic                    out_present,
    output logic [CNT_W-1:0]        occupancy
);

    logic               fire;
    logic               full;
    logic               empty;
    cmd_t               cmd;
    link_t              links [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    entry_t             res_reg;
    entry_t             res_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        cmd.push          = fire && (mode == MODE_PUSH) && !full;
        cmd.pop           = fire && (mode == MODE_POP) && !empty;
        cmd.word.level    = level;
        cmd.word.row      = tile_row;
        cmd.word.col      = tile_col;
        cmd.word.present  = tile_present;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        link_t  left;
        entry_t right_word;

        if (i == 0)
        begin : g_head
            assign left = '0;
        end
        else
        begin : g_mid
            assign left = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_word = '0;
        end
        else
        begin : g_body
            assign right_word = links[i+1].word;
        end

        smlrq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .valid      (count_reg > CNT_W'(i)),
            .left       (left),
            .right_word (right_word),
            .link       (links[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            res_next       = '0;
            if (mode == MODE_PUSH)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_PUSHED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_POPPED;
                    res_next    = links[0].word;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_level   = res_reg.level;
    assign out_row     = res_reg.row;
    assign out_col     = res_reg.col;
    assign out_present = res_reg.present;
    assign occupancy   = count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && mode == MODE_POP && !empty) |=>
        (status_reg == ST_POPPED && count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not report or decrement");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2) && links[1].word.present) |->
        (links[0].word.present && links[0].word.level <= links[1].word.level))
        else $error("head cell out of order");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && mode == MODE_PUSH && full) |=> (status_reg == ST_FULL && $stable(count_reg)))
        else $error("dropped push changed the queue");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/smlrq_cell.sv
`default_nettype none
module smlrq_cell
    import smlrq_pkg::*;
(
    input  wire logic   clk,
    input  wire cmd_t   cmd,
    input  wire logic   valid,
    input  wire link_t  left,
    input  wire entry_t right_word,
    output link_t       link
);

    entry_t word_reg;
    entry_t word_next;
    logic   gt;

    // order: present by level (older first), then tile-less newest first
    always_comb
    begin
        if (cmd.word.present)
        begin
            gt = !word_reg.present || (cmd.word.level < word_reg.level);
        end
        else
        begin
            gt = !word_reg.present;
        end
        link.ins  = !valid || gt;
        link.word = word_reg;
    end

    always_comb
    begin
        word_next = word_reg;
        if (cmd.pop)
        begin
            word_next = right_word;
        end
        else if (cmd.push)
        begin
            if (left.ins)
            begin
                word_next = left.word;
            end
            else if (link.ins)
            begin
                word_next = cmd.word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule
`default_nettype wire

>>> test/request_queue_checker.sv
module request_queue_checker
    import smlrq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               mode,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [ROW_W-1:0]   tile_row,
    input  wire logic [COL_W-1:0]   tile_col,
    input  wire logic               tile_present,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [1:0]         status,
    input  wire logic [LEVEL_W-1:0] out_level,
    input  wire logic [ROW_W-1:0]   out_row,
    input  wire logic [COL_W-1:0]   out_col,
    input  wire logic               out_present,
    input  wire logic [CNT_W-1:0]   occupancy,
    output int                      fail_count,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t          status;
        entry_t           served;
        logic [CNT_W-1:0] occupancy;
    } queue_result_t;

    entry_t        held_requests[$];
    queue_result_t expected_results[$];
    int            failures = 0;
    int            waiting  = 0;

    assign fail_count  = failures;
    assign outstanding = waiting;

    function automatic queue_result_t serve_request(input logic op, input entry_t req);
        queue_result_t res;
        int            best;
        bit            found;
        res = '0;
        if (op == MODE_PUSH) begin
            if (held_requests.size() >= DEPTH)
                res.status = ST_FULL;
            else begin
                held_requests.insert(held_requests.size(), req);
                res.status = ST_PUSHED;
            end
        end
        else if (held_requests.size() == 0)
            res.status = ST_EMPTY;
        else begin
            best  = 0;
            found = 1'b0;
            // lowest level among tiled requests, oldest wins a tie
            foreach (held_requests[i])
                if (held_requests[i].present &&
                    (!found || held_requests[i].level < held_requests[best].level)) begin
                    best  = i;
                    found = 1'b1;
                end
            if (!found)
                best = held_requests.size() - 1;
            res.served = held_requests[best];
            held_requests.delete(best);
            res.status = ST_POPPED;
        end
        res.occupancy = CNT_W'(held_requests.size());
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk) begin
        queue_result_t exp_word;
        entry_t        req;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word, status %0d occupancy %0d",
                             $time, status, occupancy);
                    failures++;
                end
                else begin
                    exp_word = expected_results.pop_front();
                    check_field("status",      exp_word.status,          status);
                    check_field("out_level",   exp_word.served.level,    out_level);
                    check_field("out_row",     exp_word.served.row,      out_row);
                    check_field("out_col",     exp_word.served.col,      out_col);
                    check_field("out_present", exp_word.served.present,  out_present);
                    check_field("occupancy",   exp_word.occupancy,       occupancy);
                end
            end
            if (in_valid && in_ready) begin
                req.level   = level;
                req.row     = tile_row;
                req.col     = tile_col;
                req.present = tile_present;
                expected_results.insert(expected_results.size(), serve_request(mode, req));
            end
            waiting = expected_results.size();
        end
    end

endmodule

>>> test/testbench.sv
module testbench;
    import smlrq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 300000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = MODE_PUSH;
    logic [LEVEL_W-1:0] level = '0;
    logic [ROW_W-1:0]   tile_row = '0;
    logic [COL_W-1:0]   tile_col = '0;
    logic               tile_present = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [LEVEL_W-1:0] out_level;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               out_present;
    logic [CNT_W-1:0]   occupancy;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count = 0;
    int                 burst_left = 1;

    always #5 clk = ~clk;

    stable_min_level_request_queue_top dut (.*);

    request_queue_checker checker_i (.*);

    // offer one word and hold it until taken; gaps fall between bursts
    task automatic send_word(input logic op, input logic [LEVEL_W-1:0] lv,
                             input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic tile);
        int gap;
        in_valid     <= 1'b1;
        mode         <= op;
        level        <= lv;
        tile_row     <= row;
        tile_col     <= col;
        tile_present <= tile;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    initial begin
        int issued;
        int span;
        int push_pct;
        int tile_pct;
        logic op;
        logic [LEVEL_W-1:0] lv;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        send_word(MODE_PUSH, 5'd31,  15'h7FFF,  16'hFFFF,   1'b1);
        send_word(MODE_PUSH, 5'd0,   '0,        '0,         1'b0);
        send_word(MODE_PUSH, 5'd5,   15'h1234,  16'h5678,   1'b1);
        send_word(MODE_PUSH, 5'd5,   15'h4321,  16'hABCD,   1'b1);
        send_word(MODE_PUSH, 5'd7,   15'h0F0F,  16'hF0F0,   1'b0);
        send_word(MODE_POP,  5'd31,  15'h7FFF,  16'hFFFF,   1'b1);
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        // only tile-less words left: newest goes first
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        send_word(MODE_PUSH, 5'd0,   15'h5555,  16'hAAAA,   1'b1);
        send_word(MODE_PUSH, 5'd0,   15'h2AAA,  16'h5555,   1'b1);
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);
        send_word(MODE_POP,  '0,     '0,        '0,         1'b0);

        issued = 0;
        while (issued < RANDOM_WORDS) begin
            if (issued == 0) begin
                // fill past full first
                push_pct = 95;
                tile_pct = 80;
                span     = 100;
            end
            else begin
                case ($urandom_range(0, 2))
                    0: push_pct = 90;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                case ($urandom_range(0, 2))
                    0: tile_pct = 90;
                    1: tile_pct = 50;
                    default: tile_pct = 10;
                endcase
                span = $urandom_range(10, 80);
            end
            for (int j = 0; j < span && issued < RANDOM_WORDS; j++) begin
                op = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
                lv = ($urandom_range(0, 9) < 7) ? LEVEL_W'($urandom_range(0, 3))
                                                 : LEVEL_W'($urandom_range(0, 31));
                send_word(op, lv, ROW_W'($urandom), COL_W'($urandom),
                          $urandom_range(0, 99) < tile_pct);
                issued++;
            end
        end
        if (in_valid)
            in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        int style;
        int span;
        int rx_cycles;
        bit hold_done;
        rx_cycles = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!hold_done && rx_cycles > 500) begin
                // long stall so the queue backs up into the input
                for (int k = 0; k < 250; k++) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                    rx_cycles++;
                end
                hold_done = 1'b1;
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(5, 60);
            for (int k = 0; k < span; k++) begin
                @(negedge clk);
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (k % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 9) < 8);
                endcase
                rx_cycles++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
